/* rtl/spf_pkg.sv */
package spf_pkg;

   localparam logic [31:0] LFSR_SEED = 32'hACE1ACE1;
   localparam logic [31:0] LFSR_TAPS = 32'hA3000000;

   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_FROM = 2'd1;
   localparam logic [1:0] OP_TO   = 2'd2;

   localparam logic REG_STRENGTH = 1'b0;
   localparam logic REG_REST     = 1'b1;

   typedef enum logic [11:0] {
      S_IDLE = 12'b0000_0000_0001,
      S_SQ   = 12'b0000_0000_0010,
      S_SQI  = 12'b0000_0000_0100,
      S_SQRT = 12'b0000_0000_1000,
      S_CHK  = 12'b0000_0001_0000,
      S_SA   = 12'b0000_0010_0000,
      S_AXI  = 12'b0000_0100_0000,
      S_MUL  = 12'b0000_1000_0000,
      S_DIV  = 12'b0001_0000_0000,
      S_FIN  = 12'b0010_0000_0000,
      S_RND  = 12'b0100_0000_0000,
      S_DONE = 12'b1000_0000_0000
   } state_type;

   typedef struct packed {
      logic       load;
      logic       zero;
      logic       sq_acc;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       sa_mul;
      logic       axis_init;
      logic       mul_step;
      logic       div_step;
      logic       axis_store;
      logic       rand_step;
      logic [1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic dist_zero;
   } status_type;

endpackage

/* rtl/spf_ctrl.sv */
module spf_ctrl import spf_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic [1:0] req_op,
   output logic       req_tready,
   input  logic       out_free,
   output logic       out_load,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int NW = 3 * WORD_BITS + 2;
   localparam int CW = $clog2(NW + 1);

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0] k_ff, k_in;
   logic active;

   assign active = (req_op == OP_FROM) || (req_op == OP_TO);
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      cmd      = '0;
      cmd.axis = k_ff;
      out_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cmd.zero = !active;
               k_in     = 2'd0;
               state_in = active ? S_SQ : S_DONE;
            end
         end
         S_SQ: begin
            cmd.sq_acc = 1'b1;
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = S_SQI;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_SQI: begin
            cmd.sqrt_init = 1'b1;
            cnt_in        = '0;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CW'(WORD_BITS)) state_in = S_CHK;
         end
         S_CHK: begin
            k_in     = 2'd0;
            state_in = status.dist_zero ? S_RND : S_SA;
         end
         S_RND: begin
            cmd.rand_step = 1'b1;
            k_in          = k_ff + 2'd1;
            if (k_ff == 2'd2) state_in = S_DONE;
         end
         S_SA: begin
            cmd.sa_mul = 1'b1;
            state_in   = S_AXI;
         end
         S_AXI: begin
            cmd.axis_init = 1'b1;
            cnt_in        = '0;
            state_in      = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(WORD_BITS)) begin
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(NW - 1)) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.axis_store = 1'b1;
            k_in           = k_ff + 2'd1;
            state_in       = (k_ff == 2'd2) ? S_DONE : S_AXI;
         end
         S_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         k_ff     <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
      end
   end

endmodule

/* rtl/spf_dp.sv */
module spf_dp import spf_pkg::*; #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [1:0]           op,
   input  logic [WORD_BITS-1:0] from_x,
   input  logic [WORD_BITS-1:0] from_y,
   input  logic [WORD_BITS-1:0] from_z,
   input  logic [WORD_BITS-1:0] to_x,
   input  logic [WORD_BITS-1:0] to_y,
   input  logic [WORD_BITS-1:0] to_z,
   input  logic [WORD_BITS-1:0] strength,
   input  logic [WORD_BITS-1:0] rest,
   output logic [WORD_BITS-1:0] force_x,
   output logic [WORD_BITS-1:0] force_y,
   output logic [WORD_BITS-1:0] force_z,
   output logic                 random_used
);

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int SW = 2 * W + 2;
   localparam int PW = 2 * W + 1;
   localparam int NW = 3 * W + 2;
   localparam int TW = NW - F;

   logic signed [W:0] d_ff [3];
   logic to_end_ff;
   logic [SW-1:0] sum_ff, src_ff;
   logic [W+1:0] srem_ff;
   logic [W:0] root_ff;
   logic [PW-1:0] p_ff;
   logic dneg_ff, neg_ff;
   logic [NW-1:0] acc_ff;
   logic [W:0] mpl_ff, drem_ff;
   logic [W-1:0] force_ff [3];
   logic rnd_ff;
   logic [31:0] lfsr_ff;

   // shared multiplier
   logic signed [W:0] d_sel;
   logic [W:0] ad, mul_a, mul_b, adelta;
   logic [SW-1:0] prod;
   logic dneg;

   assign d_sel = d_ff[cmd.axis];
   assign ad    = d_sel[W] ? (W+1)'(-d_sel) : d_sel;
   assign dneg  = root_ff < {1'b0, rest};
   assign adelta = dneg ? ({1'b0, rest} - root_ff) : (root_ff - {1'b0, rest});
   assign mul_a = cmd.sa_mul ? {1'b0, strength} : ad;
   assign mul_b = cmd.sa_mul ? adelta : ad;
   assign prod  = mul_a * mul_b;

   // square root step, two radicand bits per cycle
   logic [W+3:0] s_remx, s_trial;
   logic s_ge;
   assign s_remx  = {srem_ff, src_ff[SW-1:SW-2]};
   assign s_trial = {1'b0, root_ff, 2'b01};
   assign s_ge    = s_remx >= s_trial;

   // restoring divide step by dist
   logic [W+1:0] q_shift;
   logic q_ge;
   assign q_shift = {drem_ff, acc_ff[NW-1]};
   assign q_ge    = q_shift >= {1'b0, root_ff};

   // saturate magnitude to signed word
   logic [TW-1:0] t, half;
   logic [W-1:0] sat;
   assign t    = acc_ff[NW-1:F];
   assign half = TW'(1) << (W - 1);
   always_comb begin
      if (neg_ff) begin
         if (t > half) sat = {1'b1, {(W-1){1'b0}}};
         else          sat = W'(-t[W-1:0]);
      end else begin
         if (t >= half) sat = {1'b0, {(W-1){1'b1}}};
         else           sat = t[W-1:0];
      end
   end

   // LFSR step and random axis value
   logic [31:0] lfsr_in;
   logic signed [F+1:0] rv;
   assign lfsr_in = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : 32'd0);
   always_comb begin
      rv = $signed({1'b0, lfsr_in[F:0]}) - $signed((F+2)'(1) << F);
      if (to_end_ff) rv = -rv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_SEED;
         rnd_ff  <= 1'b0;
      end else begin
         if (cmd.rand_step) lfsr_ff <= lfsr_in;
         if (cmd.load) rnd_ff <= 1'b0;
         else if (cmd.rand_step) rnd_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         to_end_ff <= (op == OP_TO);
         d_ff[0]   <= $signed({from_x[W-1], from_x}) - $signed({to_x[W-1], to_x});
         d_ff[1]   <= $signed({from_y[W-1], from_y}) - $signed({to_y[W-1], to_y});
         d_ff[2]   <= $signed({from_z[W-1], from_z}) - $signed({to_z[W-1], to_z});
         sum_ff    <= '0;
      end
      if (cmd.zero) begin
         force_ff[0] <= '0;
         force_ff[1] <= '0;
         force_ff[2] <= '0;
      end
      if (cmd.sq_acc) sum_ff <= sum_ff + prod;
      if (cmd.sqrt_init) begin
         src_ff  <= sum_ff;
         srem_ff <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         src_ff  <= src_ff << 2;
         srem_ff <= s_ge ? (W+2)'(s_remx - s_trial) : (W+2)'(s_remx);
         root_ff <= {root_ff[W-1:0], s_ge};
      end
      if (cmd.sa_mul) begin
         p_ff    <= prod[PW-1:0];
         dneg_ff <= dneg;
      end
      if (cmd.axis_init) begin
         acc_ff  <= '0;
         drem_ff <= '0;
         mpl_ff  <= ad;
         neg_ff  <= (dneg_ff == d_sel[W]) ^ to_end_ff;
      end
      if (cmd.mul_step) begin
         acc_ff <= (acc_ff << 1) + (mpl_ff[W] ? NW'(p_ff) : '0);
         mpl_ff <= mpl_ff << 1;
      end
      if (cmd.div_step) begin
         drem_ff <= q_ge ? (W+1)'(q_shift - {1'b0, root_ff}) : q_shift[W:0];
         acc_ff  <= {acc_ff[NW-2:0], q_ge};
      end
      if (cmd.axis_store) force_ff[cmd.axis] <= sat;
      if (cmd.rand_step) force_ff[cmd.axis] <= W'(rv);
   end

   assign status.dist_zero = (root_ff == '0);
   assign force_x     = force_ff[0];
   assign force_y     = force_ff[1];
   assign force_z     = force_ff[2];
   assign random_used = rnd_ff;

endmodule

/* rtl/spring_pair_force.sv */
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tdata {to_z,to_y,to_x,from_z,from_y,from_x}, tuser op
// rsp     | out | rsp_tvalid/rsp_tready | tdata {force_z,force_y,force_x}, tuser random_used
// csr     | in  | csr_we                | csr_index, csr_wdata
// When the points differ, each item runs a bit-serial square root and then a bit-serial
// multiply and restoring divide once per axis; coincident points take an LFSR value per
// axis instead, and op none gives zero forces. Reset is synchronous and active high and
// clears control state and the LFSR.
// A finished result waits in the output register; the next item is taken meanwhile.
module spring_pair_force import spf_pkg::*; #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // from_x, from_y, from_z, to_x, to_y, to_z
   input  logic [((6*WORD_BITS+7)/8)*8-1:0]     req_tdata,
   // op
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // force_x, force_y, force_z
   output logic [((3*WORD_BITS+7)/8)*8-1:0]     rsp_tdata,
   // random_used
   output logic                                 rsp_tuser,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [WORD_BITS-1:0]                 csr_wdata
);

   localparam int W     = WORD_BITS;
   localparam int RSPDW = ((3*W+7)/8)*8;

   logic [W-1:0] strength_ff, rest_ff;
   logic [RSPDW-1:0] rsp_tdata_ff;
   logic rsp_tuser_ff, rsp_tvalid_ff;
   logic out_load, out_free;
   logic [W-1:0] force_x, force_y, force_z;
   logic random_used;
   cmd_type cmd;
   status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= W'(1) << FRAC_BITS;
         rest_ff     <= W'(1) << FRAC_BITS;
      end else if (csr_we) begin
         case (csr_index)
            REG_STRENGTH: strength_ff <= csr_wdata;
            REG_REST:     rest_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   spf_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .out_free   (out_free),
      .out_load   (out_load),
      .status     (status),
      .cmd        (cmd)
   );

   spf_dp #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .op          (req_tuser),
      .from_x      (req_tdata[W-1:0]),
      .from_y      (req_tdata[2*W-1:W]),
      .from_z      (req_tdata[3*W-1:2*W]),
      .to_x        (req_tdata[4*W-1:3*W]),
      .to_y        (req_tdata[5*W-1:4*W]),
      .to_z        (req_tdata[6*W-1:5*W]),
      .strength    (strength_ff),
      .rest        (rest_ff),
      .force_x     (force_x),
      .force_y     (force_y),
      .force_z     (force_z),
      .random_used (random_used)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_tdata_ff <= RSPDW'({force_z, force_y, force_x});
         rsp_tuser_ff <= random_used;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

/* rtl/spf_check.sv */
module spf_check #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [((3*WORD_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                             rsp_tuser
);

   localparam logic signed [WORD_BITS-1:0] UNIT = WORD_BITS'(1) << FRAC_BITS;

   logic signed [WORD_BITS-1:0] fx;
   assign fx = rsp_tdata[WORD_BITS-1:0];

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // one item in work at a time
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken twice in a row");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // random x force stays within one unit
   a_rand_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> fx >= -UNIT && fx <= UNIT)
      else $error("random force out of range");

endmodule

bind spring_pair_force spf_check #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* sim/spring_pair_force_tb.sv */
`timescale 1ns / 1ps

module spring_pair_force_tb;
   import spf_pkg::*;

   localparam int  WORD_BITS  = 32;
   localparam int  FRAC_BITS  = 16;
   localparam int  CYCLE_CAP  = 3000000;
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef logic signed [WORD_BITS-1:0] coord_type;

   typedef struct {
      logic [WORD_BITS-1:0] force_v [3];
      logic                 random_used;
   } force_result_type;

   class force_scoreboard;
      logic [WORD_BITS-1:0] strength;
      logic [WORD_BITS-1:0] rest;
      logic [31:0]          noise;
      force_result_type     expected_forces[$];
      int                   errors;

      function new();
         strength = 32'd65536;
         rest     = 32'd65536;
         noise    = LFSR_SEED;
         errors   = 0;
      endfunction

      function void set_spring(logic [WORD_BITS-1:0] s, logic [WORD_BITS-1:0] r);
         strength = s;
         rest     = r;
      endfunction

      function automatic logic [63:0] length_of(logic [127:0] v);
         logic [127:0] res;
         logic [127:0] t;
         res = '0;
         for (int i = 40; i >= 0; i--) begin
            t = res | (128'd1 << i);
            if (t * t <= v) res = t;
         end
         return res[63:0];
      endfunction

      function void note_request(logic [1:0] op, coord_type from_p [3], coord_type to_p [3]);
         force_result_type r;
         longint        d [3];
         logic [127:0]  ad [3];
         logic [127:0]  sum;
         logic [127:0]  mag;
         logic [63:0]   span;
         logic [63:0]   adelta;
         logic [16:0]   frac;
         logic          delta_neg;
         logic          to_end;
         logic          neg;
         r.force_v = '{default: '0};
         r.random_used = 1'b0;
         if (op == OP_FROM || op == OP_TO) begin
            to_end = (op == OP_TO);
            sum = '0;
            for (int k = 0; k < 3; k++) begin
               d[k]  = longint'(from_p[k]) - longint'(to_p[k]);
               ad[k] = (d[k] < 0) ? 128'(-d[k]) : 128'(d[k]);
               sum  += ad[k] * ad[k];
            end
            span = length_of(sum);
            if (span == 0) begin
               // coincident points: one noise step per axis
               for (int k = 0; k < 3; k++) begin
                  noise = noise[0] ? ((noise >> 1) ^ LFSR_TAPS) : (noise >> 1);
                  frac  = noise[FRAC_BITS:0];
                  r.force_v[k] = 32'(frac) - 32'd65536;
                  if (to_end) r.force_v[k] = -r.force_v[k];
               end
               r.random_used = 1'b1;
            end else begin
               delta_neg = span < 64'(rest);
               adelta    = delta_neg ? 64'(rest) - span : span - 64'(rest);
               for (int k = 0; k < 3; k++) begin
                  mag = (128'(strength) * 128'(adelta) * ad[k]) / (128'(span) << FRAC_BITS);
                  neg = (delta_neg == (d[k] < 0)) ^ to_end;
                  if (mag == 0) neg = 1'b0;
                  if (neg) begin
                     if (mag > 128'h8000_0000) mag = 128'h8000_0000;
                     r.force_v[k] = -mag[31:0];
                  end else begin
                     if (mag > 128'h7FFF_FFFF) mag = 128'h7FFF_FFFF;
                     r.force_v[k] = mag[31:0];
                  end
               end
            end
         end
         expected_forces.push_back(r);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
         errors++;
      endtask

      task check_response(logic [3*WORD_BITS-1:0] data, logic rnd);
         force_result_type w;
         if (expected_forces.size() == 0) begin
            report_mismatch("unexpected transfer", data[31:0], 32'd0);
            return;
         end
         w = expected_forces.pop_front();
         for (int k = 0; k < 3; k++)
            if (data[k*WORD_BITS +: WORD_BITS] !== w.force_v[k])
               report_mismatch($sformatf("force axis %0d", k),
                               data[k*WORD_BITS +: WORD_BITS], w.force_v[k]);
         if (rnd !== w.random_used)
            report_mismatch("random_used", 32'(rnd), 32'(w.random_used));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [6*WORD_BITS-1:0] req_tdata = '0;
   logic [1:0]             req_tuser = OP_NONE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [3*WORD_BITS-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we = 1'b0;
   logic                   csr_index = REG_STRENGTH;
   logic [WORD_BITS-1:0]   csr_wdata = '0;

   force_scoreboard sb = new();
   bit              calm = 1'b0;
   int              cycle_count = 0;

   spring_pair_force #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   function automatic bit go_idle();
      return !calm && ($urandom_range(99) < 36);
   endfunction

   // receiver: sample at the rising edge, change ready at the falling edge
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
         @(negedge clock);
         rsp_tready <= !go_idle();
      end
   end

   task automatic send_points(logic [1:0] op, coord_type from_p [3], coord_type to_p [3]);
      @(negedge clock);
      while (go_idle()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {to_p[2], to_p[1], to_p[0], from_p[2], from_p[1], from_p[0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, from_p, to_p);
   endtask

   task automatic send_uniform(logic [1:0] op, coord_type f, coord_type t);
      coord_type fp [3];
      coord_type tp [3];
      fp = '{f, f, f};
      tp = '{t, t, t};
      send_points(op, fp, tp);
   endtask

   task automatic send_random();
      coord_type   fp [3];
      coord_type   tp [3];
      logic [1:0]  op;
      int unsigned mode;
      int unsigned pick;
      mode = $urandom_range(9);
      pick = $urandom_range(9);
      op = (pick == 0) ? OP_NONE : (pick == 1) ? OP_SPARE : ((pick & 1) ? OP_FROM : OP_TO);
      for (int k = 0; k < 3; k++) begin
         fp[k] = $urandom;
         if (mode == 0) tp[k] = fp[k];
         else if (mode < 5)
            tp[k] = ($urandom_range(3) == 0) ? fp[k]
                    : fp[k] + coord_type'($urandom_range(524288)) - 32'sd262144;
         else tp[k] = $urandom;
      end
      send_points(op, fp, tp);
   endtask

   // write both registers back to back; block must be idle
   task automatic set_spring(logic [WORD_BITS-1:0] s, logic [WORD_BITS-1:0] r);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_STRENGTH;
      csr_wdata <= s;
      @(negedge clock);
      csr_index <= REG_REST;
      csr_wdata <= r;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.set_spring(s, r);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_forces.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) send_random();
      drain();
   endtask

   initial begin
      coord_type fp [3];
      coord_type tp [3];
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: ops, extremes, coincident points, zero force
      send_uniform(OP_NONE, 32'sd100, -32'sd100);
      send_uniform(OP_SPARE, 32'sd100, -32'sd100);
      send_uniform(OP_NONE, 32'sd5, 32'sd5);
      send_uniform(OP_FROM, 32'sd0, 32'sd0);
      send_uniform(OP_TO, 32'sd0, 32'sd0);
      send_uniform(OP_FROM, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_uniform(OP_TO, 32'h8000_0000, 32'h8000_0000);
      send_uniform(OP_FROM, 32'h7FFF_FFFF, 32'h8000_0000);
      send_uniform(OP_TO, 32'h7FFF_FFFF, 32'h8000_0000);
      send_uniform(OP_FROM, 32'h8000_0000, 32'h7FFF_FFFF);
      send_uniform(OP_TO, 32'h8000_0000, 32'h7FFF_FFFF);
      fp = '{32'sd65536, 32'sd0, 32'sd0};
      tp = '{32'sd0, 32'sd0, 32'sd0};
      send_points(OP_FROM, fp, tp);
      send_points(OP_TO, tp, fp);
      fp = '{32'sd32768, -32'sd0, 32'sd0};
      send_points(OP_FROM, fp, tp);
      fp = '{-32'sd131072, 32'sd131072, -32'sd65536};
      send_points(OP_FROM, fp, tp);
      send_points(OP_TO, fp, tp);
      fp = '{32'sd1, 32'sd0, 32'sd0};
      send_points(OP_FROM, fp, tp);
      fp = '{32'sd1, -32'sd1, 32'sd1};
      send_points(OP_TO, fp, tp);
      drain();

      run_random(150);

      set_spring(32'd0, 32'hFFFF_FFFF);
      send_uniform(OP_FROM, 32'h7FFF_FFFF, 32'h8000_0000);
      run_random(100);

      set_spring(32'hFFFF_FFFF, 32'd0);
      send_uniform(OP_FROM, 32'h7FFF_FFFF, 32'h8000_0000);
      send_uniform(OP_TO, 32'sd1, 32'sd0);
      calm = 1'b1;
      run_random(60);
      calm = 1'b0;
      run_random(60);

      set_spring($urandom, $urandom_range(300000));
      run_random(130);

      set_spring($urandom_range(200000), $urandom);
      run_random(100);

      set_spring(32'd65536, 32'd65536);
      run_random(20);

      repeat (50) @(posedge clock);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
